// ===== src/pba_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and the divider step for the block-average pixelation filter.
package pba_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int MAX_BLOCK = 64;
   localparam int HEIGHT_LIMIT = 4096;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int OFF_W  = $clog2(MAX_BLOCK);
   localparam int AREA_W = 2 * OFF_W + 1;
   localparam int SUM_W  = 8 + 2 * OFF_W;
   localparam int DIV_W  = SUM_W + 1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLOCK  = 2'd2;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic             bit_out;
   } div_step_type;

   // One restoring step: try to take divisor << shift off the remainder.
   function automatic div_step_type div_step(input logic [SUM_W-1:0] rem,
                                             input logic [AREA_W-1:0] area,
                                             input logic [2:0] shift);
      logic [DIV_W-1:0] d;
      div_step_type     r;
      d = DIV_W'(area) << shift;
      if ({1'b0, rem} >= d) begin
         r.rem     = rem - d[SUM_W-1:0];
         r.bit_out = 1'b1;
      end else begin
         r.rem     = rem;
         r.bit_out = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== src/pixelate_block_average.sv =====
`timescale 1ns / 1ps
// Block-average (mosaic) pixelation filter: tile sums in a column memory, serial divider.
//
// Pixels enter in raster order, one per transaction on the req_ channel. The
// frame is cut into square tiles of csr block_size (clamped to 1..64), tiles at
// the right and bottom edges are clipped, and when the last pixel of a tile
// arrives one rsp_ transaction carries the tile origin, its clipped size, the
// floor of its mean color and a frame_end flag on the last tile of the frame.
// Running sums for every tile of the current band of rows live in one
// 4096-entry synchronous memory addressed by the tile's origin column; the
// first pixel of a tile overwrites its entry, so no clearing pass is needed.
// Each pixel passes through a memory read, then an add and write back. A
// pixel that finishes a tile then runs an 8-step restoring division, side by
// side on the three channels against the shared tile area, and hands the
// result to the output register once that is free. The output
// register frees the input side, so a new pixel is accepted while a result is
// still stalled downstream. Any write to registers 0..2 (width, height, block
// size) restarts the frame; index 3 is ignored. Configure only while the block
// is idle; csr_ready is always high.
module pixelate_block_average import pba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_tile_col,
   output logic [11:0] rsp_tile_row,
   output logic [6:0]  rsp_tile_width,
   output logic [6:0]  rsp_tile_height,
   output logic [7:0]  rsp_avg_red,
   output logic [7:0]  rsp_avg_green,
   output logic [7:0]  rsp_avg_blue,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_DIV, ST_DONE} state_type;

   // configuration
   logic [12:0] width_ff, height_ff;
   logic [6:0]  block_ff;
   logic [12:0] w_eff, h_eff;
   logic [6:0]  bs_eff;

   // raster position
   logic [11:0]      col_ff, row_ff;
   logic [OFF_W-1:0] toff_ff, boff_ff;

   // per-pixel combinational view
   logic [11:0] ocol, orow;
   logic [12:0] wrem, hrem;
   logic [6:0]  tw, th;
   logic        last_col, last_row, done, first, accept, csr_hit;
   logic [6:0]  toff_inc, boff_inc;

   // pixel in flight
   state_type        state_ff;
   logic [7:0]       pix_r_ff, pix_g_ff, pix_b_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic             first_ff, done_ff, fend_ff;
   logic [11:0]      ocol_ff, orow_ff;
   logic [6:0]       tw_ff, th_ff;

   // tile sum memory, word = {blue, green, red}
   logic [3*SUM_W-1:0] mem [MAX_WIDTH];
   logic [3*SUM_W-1:0] mem_rd_ff;
   logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
   logic               mem_we;

   // divider
   logic [AREA_W-1:0] area_ff;
   logic [SUM_W-1:0]  rem_r_ff, rem_g_ff, rem_b_ff;
   logic [7:0]        q_r_ff, q_g_ff, q_b_ff;
   logic [2:0]        cnt_ff;
   div_step_type      st_r, st_g, st_b;

   // output register
   logic        rsp_valid_ff;
   logic [11:0] o_col_ff, o_row_ff;
   logic [6:0]  o_tw_ff, o_th_ff;
   logic [7:0]  o_r_ff, o_g_ff, o_b_ff;
   logic        o_fend_ff;
   logic        out_free;

   // clamp the registers to their legal ranges
   always_comb begin
      w_eff  = (width_ff == 13'd0) ? 13'd1 :
               (width_ff > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_ff;
      h_eff  = (height_ff == 13'd0) ? 13'd1 :
               (height_ff > 13'(HEIGHT_LIMIT)) ? 13'(HEIGHT_LIMIT) : height_ff;
      bs_eff = (block_ff == 7'd0) ? 7'd1 :
               (block_ff > 7'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : block_ff;
   end

   // tile geometry of the pixel at the current position
   always_comb begin
      ocol     = col_ff - 12'(toff_ff);
      orow     = row_ff - 12'(boff_ff);
      wrem     = w_eff - {1'b0, ocol};
      hrem     = h_eff - {1'b0, orow};
      tw       = (wrem < 13'(bs_eff)) ? wrem[6:0] : bs_eff;
      th       = (hrem < 13'(bs_eff)) ? hrem[6:0] : bs_eff;
      last_col = ({1'b0, col_ff} == w_eff - 13'd1);
      last_row = ({1'b0, row_ff} == h_eff - 13'd1);
      done     = (7'(toff_ff) == tw - 7'd1) && (7'(boff_ff) == th - 7'd1);
      first    = (toff_ff == '0) && (boff_ff == '0);
      toff_inc = 7'(toff_ff) + 7'd1;
      boff_inc = 7'(boff_ff) + 7'd1;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready &&
                      (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT ||
                       csr_index == CSR_BLOCK);

   // configuration registers and raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         block_ff  <= 7'd8;
         col_ff    <= '0;
         row_ff    <= '0;
         toff_ff   <= '0;
         boff_ff   <= '0;
      end else if (csr_hit) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_BLOCK:  block_ff  <= csr_data[6:0];
            default:    ;
         endcase
         col_ff  <= '0;
         row_ff  <= '0;
         toff_ff <= '0;
         boff_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff  <= '0;
            toff_ff <= '0;
            if (last_row) begin
               row_ff  <= '0;
               boff_ff <= '0;
            end else begin
               row_ff  <= row_ff + 12'd1;
               boff_ff <= (boff_inc == bs_eff) ? '0 : boff_inc[OFF_W-1:0];
            end
         end else begin
            col_ff  <= col_ff + 12'd1;
            toff_ff <= (toff_inc == bs_eff) ? '0 : toff_inc[OFF_W-1:0];
         end
      end
   end

   // add the pixel to the entry just read, or start a fresh tile
   always_comb begin
      sum_r  = first_ff ? SUM_W'(pix_r_ff) : mem_rd_ff[SUM_W-1:0] + SUM_W'(pix_r_ff);
      sum_g  = first_ff ? SUM_W'(pix_g_ff) :
               mem_rd_ff[2*SUM_W-1:SUM_W] + SUM_W'(pix_g_ff);
      sum_b  = first_ff ? SUM_W'(pix_b_ff) :
               mem_rd_ff[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_b_ff);
      mem_we = (state_ff == ST_ACC);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= {sum_b, sum_g, sum_r};
      end
      if (accept) begin
         mem_rd_ff <= mem[ocol[ADDR_W-1:0]];
      end
   end

   always_comb begin
      st_r     = div_step(rem_r_ff, area_ff, cnt_ff);
      st_g     = div_step(rem_g_ff, area_ff, cnt_ff);
      st_b     = div_step(rem_b_ff, area_ff, cnt_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // sequencer: read, accumulate, divide, hand off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (done_ff) begin
                  state_ff <= ST_DIV;
                  cnt_ff   <= 3'd7;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff - 3'd1;
               if (cnt_ff == 3'd0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_r_ff <= req_red;
         pix_g_ff <= req_green;
         pix_b_ff <= req_blue;
         addr_ff  <= ocol[ADDR_W-1:0];
         first_ff <= first;
         done_ff  <= done;
         fend_ff  <= last_col && last_row;
         ocol_ff  <= ocol;
         orow_ff  <= orow;
         tw_ff    <= tw;
         th_ff    <= th;
      end
      if (state_ff == ST_ACC) begin
         area_ff  <= AREA_W'(tw_ff) * AREA_W'(th_ff);
         rem_r_ff <= sum_r;
         rem_g_ff <= sum_g;
         rem_b_ff <= sum_b;
         q_r_ff   <= '0;
         q_g_ff   <= '0;
         q_b_ff   <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_r_ff <= st_r.rem;
         rem_g_ff <= st_g.rem;
         rem_b_ff <= st_b.rem;
         q_r_ff   <= {q_r_ff[6:0], st_r.bit_out};
         q_g_ff   <= {q_g_ff[6:0], st_g.bit_out};
         q_b_ff   <= {q_b_ff[6:0], st_b.bit_out};
      end
      if (state_ff == ST_DONE && out_free) begin
         o_col_ff  <= ocol_ff;
         o_row_ff  <= orow_ff;
         o_tw_ff   <= tw_ff;
         o_th_ff   <= th_ff;
         o_r_ff    <= q_r_ff;
         o_g_ff    <= q_g_ff;
         o_b_ff    <= q_b_ff;
         o_fend_ff <= fend_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_col    = o_col_ff;
   assign rsp_tile_row    = o_row_ff;
   assign rsp_tile_width  = o_tw_ff;
   assign rsp_tile_height = o_th_ff;
   assign rsp_avg_red     = o_r_ff;
   assign rsp_avg_green   = o_g_ff;
   assign rsp_avg_blue    = o_b_ff;
   assign rsp_frame_end   = o_fend_ff;

   a_acc_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> $past(accept))
      else $error("accumulate without an accepted pixel");

   a_div_from_done_tile: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !done_ff) |=> state_ff == ST_IDLE)
      else $error("unfinished tile entered the divider");

   a_rsp_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tile_width != 7'd0 && rsp_tile_height != 7'd0))
      else $error("result with empty tile");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> state_ff == ST_DONE)
      else $error("result overwrote a stalled transaction");

endmodule

// ===== test/pba_checker.sv =====
`timescale 1ns / 1ps
// Tile-average predictor and result checker for the pixelation filter.
module pba_checker import pba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_tile_col,
   input  logic [11:0] rsp_tile_row,
   input  logic [6:0]  rsp_tile_width,
   input  logic [6:0]  rsp_tile_height,
   input  logic [7:0]  rsp_avg_red,
   input  logic [7:0]  rsp_avg_green,
   input  logic [7:0]  rsp_avg_blue,
   input  logic        rsp_frame_end,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   output int          mismatches,
   output int          tiles_pending,
   output int          tiles_checked
);

   typedef struct {
      logic [11:0] col;
      logic [11:0] row;
      logic [6:0]  width;
      logic [6:0]  height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        frame_end;
   } tile_type;

   tile_type tile_q[$];

   logic [12:0] cfg_width, cfg_height;
   logic [6:0]  cfg_block;
   int unsigned col_pos, row_pos, col_off, row_off;
   int unsigned sum_r[MAX_WIDTH], sum_g[MAX_WIDTH], sum_b[MAX_WIDTH];

   assign tiles_pending = tile_q.size();

   function automatic int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic report(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: tile %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, bs, ocol, orow, tw, th, idx, area;
      tile_type t;
      w  = clamp(cfg_width, MAX_WIDTH);
      h  = clamp(cfg_height, HEIGHT_LIMIT);
      bs = clamp(cfg_block, MAX_BLOCK);
      if (col_pos >= w || col_off > col_pos || col_off >= bs) begin
         col_pos = 0;
         col_off = 0;
      end
      if (row_pos >= h || row_off > row_pos || row_off >= bs) begin
         row_pos = 0;
         row_off = 0;
      end
      ocol = col_pos - col_off;
      orow = row_pos - row_off;
      tw = (w - ocol < bs) ? w - ocol : bs;
      th = (h - orow < bs) ? h - orow : bs;
      idx = ocol % MAX_WIDTH;
      if (col_off == 0 && row_off == 0) begin
         sum_r[idx] = r;
         sum_g[idx] = g;
         sum_b[idx] = b;
      end else begin
         sum_r[idx] += r;
         sum_g[idx] += g;
         sum_b[idx] += b;
      end
      if (col_off == tw - 1 && row_off == th - 1) begin
         area = tw * th;
         t.col = 12'(ocol);
         t.row = 12'(orow);
         t.width = 7'(tw);
         t.height = 7'(th);
         t.red = 8'(sum_r[idx] / area);
         t.green = 8'(sum_g[idx] / area);
         t.blue = 8'(sum_b[idx] / area);
         t.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
         tile_q.push_back(t);
      end
      if (col_pos == w - 1) begin
         col_pos = 0;
         col_off = 0;
         if (row_pos == h - 1) begin
            row_pos = 0;
            row_off = 0;
         end else begin
            row_pos++;
            row_off = (row_off + 1 == bs) ? 0 : row_off + 1;
         end
      end else begin
         col_pos++;
         col_off = (col_off + 1 == bs) ? 0 : col_off + 1;
      end
   endtask

   always @(posedge clock) begin
      tile_type t;
      if (reset) begin
         cfg_width = 13'd640;
         cfg_height = 13'd480;
         cfg_block = 7'd8;
         col_pos = 0; row_pos = 0; col_off = 0; row_off = 0;
         tile_q.delete();
         mismatches = 0;
         tiles_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  cfg_width = csr_data;
               CSR_HEIGHT: cfg_height = csr_data;
               CSR_BLOCK:  cfg_block = csr_data[6:0];
               default: ;
            endcase
            if (csr_index inside {CSR_WIDTH, CSR_HEIGHT, CSR_BLOCK}) begin
               col_pos = 0; row_pos = 0; col_off = 0; row_off = 0;
            end
         end
         if (req_valid && !req_stall)
            accumulate_pixel(req_red, req_green, req_blue);
         if (rsp_valid && !rsp_stall) begin
            if (tile_q.size() == 0) begin
               report("unexpected", rsp_tile_col, -1);
            end else begin
               t = tile_q.pop_front();
               tiles_checked++;
               if (rsp_tile_col != t.col) report("col", rsp_tile_col, t.col);
               if (rsp_tile_row != t.row) report("row", rsp_tile_row, t.row);
               if (rsp_tile_width != t.width) report("width", rsp_tile_width, t.width);
               if (rsp_tile_height != t.height)
                  report("height", rsp_tile_height, t.height);
               if (rsp_avg_red != t.red) report("avg_red", rsp_avg_red, t.red);
               if (rsp_avg_green != t.green) report("avg_green", rsp_avg_green, t.green);
               if (rsp_avg_blue != t.blue) report("avg_blue", rsp_avg_blue, t.blue);
               if (rsp_frame_end != t.frame_end)
                  report("frame_end", rsp_frame_end, t.frame_end);
            end
         end
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the block-average pixelation filter.
module tb;
   import pba_pkg::*;

   // Index 3 is decoded as nothing; writing it must not restart the frame.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [7:0]  req_red, req_green, req_blue;
   logic        rsp_valid, rsp_stall;
   logic [11:0] rsp_tile_col, rsp_tile_row;
   logic [6:0]  rsp_tile_width, rsp_tile_height;
   logic [7:0]  rsp_avg_red, rsp_avg_green, rsp_avg_blue;
   logic        rsp_frame_end;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   int mismatches, tiles_pending, tiles_checked;
   int pixels_sent, frames_set;
   bit calm;   // when set, neither side idles

   pixelate_block_average DUT (.*);

   pba_checker scoreboard (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Fail the run if it hangs anywhere.
   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Downstream backpressure: hold stall for random stretches.
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         n = calm ? 0 : gap_len();
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         repeat ($urandom_range(1, 12)) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [12:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drive one pixel after an optional gap; hold it until accepted.
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int n;
      n = calm ? 0 : gap_len();
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // Drop valid and wait for every predicted tile, then let any
   // in-flight pixel settle before the registers move.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tiles_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [12:0] bs);
      drain();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_BLOCK, bs);
      frames_set++;
   endtask

   task automatic send_random(int n);
      repeat (n) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
   endtask

   initial begin
      int w, h, bs, n;
      reset = 1;
      req_valid = 0; req_red = 0; req_green = 0; req_blue = 0;
      csr_valid = 0; csr_index = CSR_WIDTH; csr_data = 0;
      calm = 0;
      pixels_sent = 0;
      frames_set = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // 3x3 frame of 2x2 tiles: full, right-clipped, bottom-clipped and corner
      // tiles, with channel extremes; a spare-index write mid-frame must not
      // restart the count.
      set_frame(13'd3, 13'd3, 13'd2);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd0);
      drain();
      write_csr(CSR_SPARE, 13'h1fff);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd128, 8'd127, 8'd1);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd7, 8'd8, 8'd9);

      // Zero registers act as 1: every pixel is its own frame.
      set_frame(13'd0, 13'd0, 13'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'h55, 8'haa, 8'h0f);

      // Oversized registers clamp to 4096 x 4096 with 64-pixel tiles.
      set_frame(13'h1fff, 13'h1fff, 13'h7f);
      send_random(4);

      // Block larger than the frame: one clipped tile per frame.
      set_frame(13'd2, 13'd2, 13'd64);
      send_random(8);

      // Random frames; most small, a few with wide tiles or clamped sizes.
      while (pixels_sent < 1650) begin
         case ($urandom_range(0, 9))
            0: begin w = $urandom_range(60, 130); h = $urandom_range(1, 3);
                  bs = 64; end
            1: begin w = 0; h = $urandom_range(0, 3); bs = $urandom_range(0, 3); end
            2: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12);
                  bs = $urandom_range(65, 127); end
            default: begin
               w = $urandom_range(1, 20);
               h = $urandom_range(1, 12);
               bs = $urandom_range(1, 8);
            end
         endcase
         calm = ($urandom_range(0, 4) == 0);
         set_frame(13'(w), 13'(h), 13'(bs));
         if ($urandom_range(0, 7) == 0) write_csr(CSR_SPARE, 13'($urandom));
         n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
         n = $urandom_range(1, 2 * n + 3);
         if (n > 260) n = 260;
         if (n > 1650 - pixels_sent) n = 1650 - pixels_sent;
         send_random(n);
      end
      calm = 0;

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d pixels over %0d frame settings, %0d tiles checked.",
               pixels_sent, frames_set, tiles_checked);
      $display("Covered clipped edge tiles, register clamping and spare-index writes.");
      if (mismatches == 0 && tiles_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pba_pkg.sv
src/pixelate_block_average.sv
test/pba_checker.sv
test/tb.sv
